[rtl/core/srtq_pkg.sv]
// Shared types, constants and codes of the relay toggle queue.
package srtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DELAY_BITS_DEF  = 16;

  localparam int KIND_W    = 2;
  localparam int ELAPSED_W = 16;
  localparam int DLY_IN_W  = 16;
  localparam int PENDING_W = 5;
  localparam int HEAD_W    = 16;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // register indexes (byte address bit 2)
  localparam logic CFG_IDX_MODE  = 1'b0;
  localparam logic CFG_IDX_LEVEL = 1'b1;

  // config side -> controller
  typedef struct packed {
    logic relay_mode;
    logic load_level;
    logic level_value;
  } cfg_ctl_t;

endpackage

[rtl/core/srtq_if.sv]
// Item channels: command input and result output.
interface srtq_in_if import srtq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ELAPSED_W-1:0] elapsed;
  logic [DLY_IN_W-1:0]  delay;

  modport source (output valid, kind, elapsed, delay, input ready);
  modport sink   (input valid, kind, elapsed, delay, output ready);
endinterface

interface srtq_out_if import srtq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 level;
  logic                 toggled;
  logic                 pulse;
  logic                 overflow;
  logic [PENDING_W-1:0] pending;
  logic [HEAD_W-1:0]    head_remaining;

  modport source (output valid, level, toggled, pulse, overflow, pending, head_remaining,
                  input ready);
  modport sink   (input valid, level, toggled, pulse, overflow, pending, head_remaining,
                  output ready);
endinterface

[rtl/core/srtq_mem.sv]
// Delay queue storage: one write port, one read port with registered data.
module srtq_mem import srtq_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int WIDTH = DELAY_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/srtq_cfg.sv]
// APB-style register file: relay mode and initial level load.
module srtq_cfg import srtq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_ctl_t              cfg
);

  logic relay_mode_r;
  logic initial_level_r;
  logic wr_fire;
  logic idx;

  assign pready  = 1'b1;
  assign wr_fire = psel & penable & pwrite;
  assign idx     = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_mode_r    <= 1'b0;
      initial_level_r <= 1'b0;
    end else if (wr_fire) begin
      if (idx == CFG_IDX_MODE) begin
        relay_mode_r <= pwdata[0];
      end else begin
        initial_level_r <= pwdata[0];
      end
    end
  end

  always_comb begin
    case (idx)
      CFG_IDX_MODE:  prdata = {{(CFG_DATA_W-1){1'b0}}, relay_mode_r};
      CFG_IDX_LEVEL: prdata = {{(CFG_DATA_W-1){1'b0}}, initial_level_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.relay_mode  = relay_mode_r;
  assign cfg.load_level  = wr_fire & (idx == CFG_IDX_LEVEL);
  assign cfg.level_value = pwdata[0];

endmodule

[rtl/core/srtq_ctrl.sv]
// Sequencer: reads the head entry, updates it or pops it, appends, clears.
module srtq_ctrl import srtq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int DELAY_BITS  = DELAY_BITS_DEF,
  localparam int PTR_W      = $clog2(QUEUE_DEPTH),
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_ctl_t              cfg,
  srtq_in_if.sink               in_ch,
  srtq_out_if.source            out_ch,
  output logic                  wr_en,
  output logic [PTR_W-1:0]      wr_addr,
  output logic [DELAY_BITS-1:0] wr_data,
  output logic [PTR_W-1:0]      rd_addr,
  input  logic [DELAY_BITS-1:0] rd_data
);

  localparam int CMP_W = (DELAY_BITS > ELAPSED_W) ? DELAY_BITS : ELAPSED_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FETCH, S_LOAD, S_DONE} state_t;

  state_t                state_r, state_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  level_r, level_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [DELAY_BITS-1:0] delay_r, delay_nxt;
  logic                  res_toggled_r, res_toggled_nxt;
  logic                  res_overflow_r, res_overflow_nxt;
  logic [DELAY_BITS-1:0] res_head_r, res_head_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_level_r, out_level_nxt;
  logic                  out_toggled_r, out_toggled_nxt;
  logic                  out_pulse_r, out_pulse_nxt;
  logic                  out_overflow_r, out_overflow_nxt;
  logic [PENDING_W-1:0]  out_pending_r, out_pending_nxt;
  logic [HEAD_W-1:0]     out_head_r, out_head_nxt;

  logic [CMP_W-1:0]      head_ext;
  logic [CMP_W-1:0]      elapsed_ext;
  logic [CMP_W-1:0]      diff;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign rd_addr     = head_r;   // head entry always on the read port

  assign head_ext    = CMP_W'(rd_data);
  assign elapsed_ext = CMP_W'(elapsed_r);
  assign diff        = head_ext - elapsed_ext;

  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    count_nxt        = count_r;
    level_nxt        = cfg.load_level ? cfg.level_value : level_r;
    kind_nxt         = kind_r;
    elapsed_nxt      = elapsed_r;
    delay_nxt        = delay_r;
    res_toggled_nxt  = res_toggled_r;
    res_overflow_nxt = res_overflow_r;
    res_head_nxt     = res_head_r;
    out_valid_nxt    = out_valid_r & ~out_ch.ready;
    out_level_nxt    = out_level_r;
    out_toggled_nxt  = out_toggled_r;
    out_pulse_nxt    = out_pulse_r;
    out_overflow_nxt = out_overflow_r;
    out_pending_nxt  = out_pending_r;
    out_head_nxt     = out_head_r;
    wr_en            = 1'b0;
    wr_addr          = head_r;
    wr_data          = DELAY_BITS'(diff);

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt    = in_ch.kind;
          elapsed_nxt = in_ch.elapsed;
          delay_nxt   = DELAY_BITS'(in_ch.delay);
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        res_toggled_nxt  = 1'b0;
        res_overflow_nxt = 1'b0;
        res_head_nxt     = (count_r != '0) ? rd_data : '0;
        state_nxt        = S_DONE;
        case (kind_r)
          KIND_TICK: begin
            if (count_r != '0) begin
              if (head_ext > elapsed_ext) begin
                wr_en        = 1'b1;
                res_head_nxt = DELAY_BITS'(diff);
              end else begin
                level_nxt       = ~level_r;
                res_toggled_nxt = 1'b1;
                head_nxt        = ptr_inc(head_r);
                count_nxt       = count_r - 1'b1;
                res_head_nxt    = '0;
                // new head must come from the memory
                if (count_r != CNT_W'(1)) begin
                  state_nxt = S_FETCH;
                end
              end
            end
          end
          KIND_ADD: begin
            if (count_r == FULL_CNT) begin
              res_overflow_nxt = 1'b1;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = tail_r;
              wr_data   = delay_r;
              tail_nxt  = ptr_inc(tail_r);
              count_nxt = count_r + 1'b1;
              if (count_r == '0) begin
                res_head_nxt = delay_r;
              end
            end
          end
          KIND_CLEAR: begin
            head_nxt     = '0;
            tail_nxt     = '0;
            count_nxt    = '0;
            res_head_nxt = '0;
            if (level_r) begin
              level_nxt       = 1'b0;
              res_toggled_nxt = 1'b1;
            end
          end
          default: begin
            // unused kind: report current state only
          end
        endcase
      end
      S_FETCH: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        res_head_nxt = rd_data;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt    = 1'b1;
          out_level_nxt    = level_r;
          out_toggled_nxt  = res_toggled_r;
          out_pulse_nxt    = res_toggled_r & cfg.relay_mode;
          out_overflow_nxt = res_overflow_r;
          out_pending_nxt  = PENDING_W'(count_r);
          out_head_nxt     = HEAD_W'(res_head_r);
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r         <= kind_nxt;
    elapsed_r      <= elapsed_nxt;
    delay_r        <= delay_nxt;
    res_toggled_r  <= res_toggled_nxt;
    res_overflow_r <= res_overflow_nxt;
    res_head_r     <= res_head_nxt;
    out_level_r    <= out_level_nxt;
    out_toggled_r  <= out_toggled_nxt;
    out_pulse_r    <= out_pulse_nxt;
    out_overflow_r <= out_overflow_nxt;
    out_pending_r  <= out_pending_nxt;
    out_head_r     <= out_head_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.level          = out_level_r;
  assign out_ch.toggled        = out_toggled_r;
  assign out_ch.pulse          = out_pulse_r;
  assign out_ch.overflow       = out_overflow_r;
  assign out_ch.pending        = out_pending_r;
  assign out_ch.head_remaining = out_head_r;

  // occupancy never exceeds the queue
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");

  // empty or full queue has coinciding pointers
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_CNT) |-> head_r == tail_r)
    else $error("head/tail mismatch for empty or full queue");

  // memory is written only while an item executes
  a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == S_EXEC)
    else $error("memory write outside execute step");

  // a pulse is only raised on a toggle
  a_pulse_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pulse_r |-> out_toggled_r)
    else $error("pulse without toggle");

  // an accepted item always takes the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_EXEC)
    else $error("accepted item not executed");

endmodule

[rtl/core/scheduled_relay_toggle_queue.sv]
// Top level: relay toggle queue with delay memory, sequencer and register port.
// Each accepted item passes the execute and done states; done loads the output
//   register once it is free. A popping tick with entries left also passes fetch
//   and load (extra memory read of the new head). One item at a time, set by the
//   sequencer and the single registered read port of the delay memory.
// Reset: synchronous, active low; clears pointers, count, relay level, registers
//   and the output valid flag. Delay memory is not cleared (no clearing pass).
module scheduled_relay_toggle_queue import srtq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int DELAY_BITS  = DELAY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  srtq_in_if.sink               in_ch,
  srtq_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cfg_ctl_t              cfg;
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [DELAY_BITS-1:0] wr_data;
  logic [PTR_W-1:0]      rd_addr;
  logic [DELAY_BITS-1:0] rd_data;

  // registers: mode at 0x0, initial level at 0x4 (write loads the relay level)
  srtq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: one item at a time, read-modify-write on the head entry
  srtq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DELAY_BITS  (DELAY_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // delay FIFO storage; entries are only used after being written
  srtq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (DELAY_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

[verif/scheduled_relay_toggle_queue_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the relay toggle queue: driver, monitor, predictor, APB setup.
module scheduled_relay_toggle_queue_test;
  import srtq_pkg::*;

  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam int SETTLE_CYCLES  = 8;     // covers the longest item path, with margin
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is declared hung
  localparam int RANDOM_ITEMS   = 325;   // per random phase, four phases

  // kind code the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ELAPSED_W-1:0] elapsed;
    logic [DLY_IN_W-1:0]  dly;
  } relay_cmd_t;

  typedef struct packed {
    logic                 level;
    logic                 toggled;
    logic                 pulse;
    logic                 overflow;
    logic [PENDING_W-1:0] pending;
    logic [HEAD_W-1:0]    head_remaining;
  } relay_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  srtq_in_if  in_ch ();
  srtq_out_if out_ch ();

  scheduled_relay_toggle_queue i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block state: delay FIFO, pointers, fill count, relay level
  // and the mode register. Pointers are 4 bits so they wrap at DEPTH by themselves.
  // ---------------------------------------------------------------------------
  logic [DLY_IN_W-1:0]  delay_mem [DEPTH];
  logic [3:0]           rd_ptr;
  logic [3:0]           wr_ptr;
  logic [PENDING_W-1:0] fill;
  logic                 relay_up;
  logic                 push_mode;

  relay_cmd_t    cmd_fifo[$];        // items waiting for the driver
  relay_result_t expected_results[$];

  int in_gap_max;
  int out_stall_max;
  int n_errors;
  int n_sent;
  int n_results;
  int n_toggles;
  int n_pulses;
  int n_overflows;
  int n_clears;
  int quiet_cycles;

  // Apply one item to the shadow state and return what the block must report.
  function automatic relay_result_t relay_step(relay_cmd_t cmd);
    relay_result_t r;
    r = '0;
    case (cmd.kind)
      KIND_TICK: begin
        if (fill != 0) begin
          // not-greater test: a head equal to elapsed fires, leftover time is dropped
          if (delay_mem[rd_ptr] > cmd.elapsed) begin
            delay_mem[rd_ptr] = delay_mem[rd_ptr] - cmd.elapsed;
          end else begin
            relay_up  = ~relay_up;
            r.toggled = 1'b1;
            rd_ptr    = rd_ptr + 1'b1;
            fill      = fill - 1'b1;
          end
        end
      end
      KIND_ADD: begin
        if (fill == DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          delay_mem[wr_ptr] = cmd.dly;
          wr_ptr = wr_ptr + 1'b1;
          fill   = fill + 1'b1;
        end
      end
      KIND_CLEAR: begin
        fill   = '0;
        rd_ptr = '0;
        wr_ptr = '0;
        if (relay_up) begin
          relay_up  = 1'b0;
          r.toggled = 1'b1;
        end
      end
      default: ;  // unused kind: state unchanged, current state reported
    endcase
    r.level          = relay_up;
    r.pulse          = r.toggled & push_mode;
    r.pending        = fill;
    r.head_remaining = (fill != 0) ? delay_mem[rd_ptr] : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes items from cmd_fifo, waits a random gap after each one.
  // The expectation is computed at the edge where the item is accepted.
  // ---------------------------------------------------------------------------
  int in_gap;

  always @(posedge clk) begin
    relay_cmd_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        c.kind    = in_ch.kind;
        c.elapsed = in_ch.elapsed;
        c.dly     = in_ch.delay;
        expected_results.push_back(relay_step(c));
        n_sent++;
        if (c.kind == KIND_CLEAR) n_clears++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_fifo.size() != 0) begin
          c = cmd_fifo.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.kind    <= c.kind;
          in_ch.elapsed <= c.elapsed;
          in_ch.delay   <= c.dly;
          in_gap = $urandom_range(0, in_gap_max);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall after each result, field-by-field compare against
  // the oldest expectation.
  // ---------------------------------------------------------------------------
  int out_stall;

  always @(posedge clk) begin
    relay_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (out_ch.toggled === 1'b1)  n_toggles++;
        if (out_ch.pulse === 1'b1)    n_pulses++;
        if (out_ch.overflow === 1'b1) n_overflows++;
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          n_errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.level !== e.level) begin
            $error("level: expected %0d, got %0d", e.level, out_ch.level);
            n_errors++;
          end
          if (out_ch.toggled !== e.toggled) begin
            $error("toggled: expected %0d, got %0d", e.toggled, out_ch.toggled);
            n_errors++;
          end
          if (out_ch.pulse !== e.pulse) begin
            $error("pulse: expected %0d, got %0d", e.pulse, out_ch.pulse);
            n_errors++;
          end
          if (out_ch.overflow !== e.overflow) begin
            $error("overflow: expected %0d, got %0d", e.overflow, out_ch.overflow);
            n_errors++;
          end
          if (out_ch.pending !== e.pending) begin
            $error("pending: expected %0d, got %0d", e.pending, out_ch.pending);
            n_errors++;
          end
          if (out_ch.head_remaining !== e.head_remaining) begin
            $error("head_remaining: expected %0d, got %0d",
                   e.head_remaining, out_ch.head_remaining);
            n_errors++;
          end
        end
        out_stall = $urandom_range(0, out_stall_max);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends a hung run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // APB write: setup, access, register taken at the edge with pready high.
  task automatic reg_write(input logic idx, input logic value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(CFG_DATA_W-1){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == CFG_IDX_MODE) push_mode = value;
    else                     relay_up  = value;
  endtask

  task automatic push_cmd(input logic [KIND_W-1:0] kind, input logic [ELAPSED_W-1:0] elapsed,
                          input logic [DLY_IN_W-1:0] dly);
    relay_cmd_t c;
    c.kind    = kind;
    c.elapsed = elapsed;
    c.dly     = dly;
    cmd_fifo.push_back(c);
  endtask

  // Mostly short delays and ticks so the relay toggles often; full-range values
  // now and then. The field that a kind does not use carries random noise.
  function automatic relay_cmd_t random_cmd();
    relay_cmd_t c;
    int pick;
    pick      = $urandom_range(0, 99);
    c.elapsed = 16'($urandom);
    c.dly     = 16'($urandom);
    if (pick < 45) begin
      c.kind = KIND_TICK;
      if (pick >= 6) c.elapsed = 16'($urandom_range(0, 40));
    end else if (pick < 88) begin
      c.kind = KIND_ADD;
      if (pick >= 50) c.dly = 16'($urandom_range(0, 60));
    end else if (pick < 94) begin
      c.kind = KIND_CLEAR;
    end else begin
      c.kind = KIND_UNUSED;
    end
    return c;
  endfunction

  task automatic queue_random(input int n_items);
    relay_cmd_t c;
    int counted;
    counted = 0;
    while (counted < n_items) begin
      if ($urandom_range(0, 49) == 0) begin
        // run of appends long enough to hit the full queue
        repeat (DEPTH + 3) begin
          c = random_cmd();
          c.kind = KIND_ADD;
          cmd_fifo.push_back(c);
        end
        counted += DEPTH + 3;
      end else begin
        c = random_cmd();
        cmd_fifo.push_back(c);
        counted++;
      end
    end
  endtask

  // Block idle: nothing left to send, nothing in flight, then settle time.
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_fifo.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input logic mode, input logic level, input int gap_max,
                              input int stall_max);
    reg_write(CFG_IDX_MODE, mode);
    reg_write(CFG_IDX_LEVEL, level);
    @(negedge clk);
    in_gap_max    = gap_max;
    out_stall_max = stall_max;
    queue_random(RANDOM_ITEMS);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_TICK;
    in_ch.elapsed = '0;
    in_ch.delay   = '0;
    out_ch.ready  = 1'b0;
    rd_ptr        = '0;
    wr_ptr        = '0;
    fill          = '0;
    relay_up      = 1'b0;
    push_mode     = 1'b0;
    in_gap_max    = 9;
    out_stall_max = 9;
    n_errors      = 0;
    n_sent        = 0;
    n_results     = 0;
    n_toggles     = 0;
    n_pulses      = 0;
    n_overflows   = 0;
    n_clears      = 0;
    quiet_cycles  = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, continuous mode, level down.
    reg_write(CFG_IDX_MODE, 1'b0);
    reg_write(CFG_IDX_LEVEL, 1'b0);
    @(negedge clk);
    push_cmd(KIND_TICK, 16'hFFFF, 16'hFFFF);   // tick on empty queue: no change
    push_cmd(KIND_ADD, 16'h0000, 16'h0000);    // zero delay ...
    push_cmd(KIND_TICK, 16'h0000, 16'h0000);   // ... fires even on zero elapsed
    push_cmd(KIND_ADD, 16'h0000, 16'hFFFF);    // largest delay
    push_cmd(KIND_TICK, 16'hFFFE, 16'h0000);   // leaves 1
    push_cmd(KIND_TICK, 16'h0001, 16'h0000);   // equal: fires, queue empty again
    push_cmd(KIND_ADD, 16'h0000, 16'h0005);
    push_cmd(KIND_TICK, 16'hFFFF, 16'h0000);   // elapsed well past head, leftover dropped
    push_cmd(KIND_CLEAR, 16'h0000, 16'h0000);  // level up: clear pulls it down
    push_cmd(KIND_CLEAR, 16'hFFFF, 16'hFFFF);  // level down: no toggle
    for (int i = 0; i < DEPTH; i++)
      push_cmd(KIND_ADD, 16'($urandom), 16'($urandom));
    push_cmd(KIND_ADD, 16'h0000, 16'hFFFF);    // queue full: dropped, overflow
    push_cmd(KIND_UNUSED, 16'hFFFF, 16'hFFFF); // ignored, state reported
    wait_idle();

    // Random phases: push and continuous mode, both start levels, with and
    // without idling on each side.
    random_phase(1'b1, 1'b1, 9, 9);
    random_phase(1'b0, 1'b1, 0, 0);
    random_phase(1'b1, 1'b0, 0, 9);
    random_phase(1'b0, 1'b0, 9, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d results checked, %0d clears", n_sent, n_results, n_clears);
    $display("%0d toggles, %0d pulse requests, %0d overflows, %0d mismatches",
             n_toggles, n_pulses, n_overflows, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
